[rtl/gia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_pkg
// Shared types and constants of the gyro interval averager.
// ----------------------------------------------------------------------------
package gia_pkg;

    localparam int unsigned RATE_W   = 24;
    localparam int unsigned TIME_W   = 63;
    localparam int unsigned STATUS_W = 2;
    // magnitude of a rate difference, one interpolation step per bit
    localparam int unsigned MAG_W    = RATE_W + 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_BAD_INTERVAL = 2'd1,
        ST_NO_COVERAGE  = 2'd2,
        ST_OUT_OF_ORDER = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_START_INIT,
        S_START_STEP,
        S_START_SET,
        S_CHECK,
        S_END_INIT,
        S_END_STEP,
        S_DT_LOAD,
        S_MUL,
        S_ACC,
        S_DIV_INIT,
        S_DIV_STEP,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    accept_en;
        logic    q_clear;
        logic    q_arm;
        logic    interp_init;
        logic    interp_tgt_end;
        logic    interp_step;
        logic    seg_start;
        logic    dt_load;
        logic    dt_end;
        logic    ax_clr;
        logic    mul;
        logic    use_er;
        logic    acc;
        logic    div_init;
        logic    div_step;
        logic    seg_advance;
        logic    prev_update;
        logic    out_load;
        t_status out_code;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic is_query;
        logic bad_iv;
        logic no_cov;
        logic ooo;
        logic qa;
        logic qs;
        logic start_hit;
        logic end_hit;
        logic cnt_zero;
        logic ax_last;
        logic out_free;
    } t_stat;

endpackage

[rtl/gia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_in_if / gia_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gia_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [gia_pkg::TIME_W-1:0]            sample_time;
    logic signed [gia_pkg::RATE_W-1:0]     rate_x;
    logic signed [gia_pkg::RATE_W-1:0]     rate_y;
    logic signed [gia_pkg::RATE_W-1:0]     rate_z;
    logic [gia_pkg::TIME_W-1:0]            start_time;
    logic [gia_pkg::TIME_W-1:0]            end_time;

    modport source (output valid, kind, sample_time, rate_x, rate_y, rate_z,
                    start_time, end_time, input ready);
    modport sink   (input valid, kind, sample_time, rate_x, rate_y, rate_z,
                    start_time, end_time, output ready);
endinterface

interface gia_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [gia_pkg::STATUS_W-1:0]          status;
    logic signed [gia_pkg::RATE_W-1:0]     avg_x;
    logic signed [gia_pkg::RATE_W-1:0]     avg_y;
    logic signed [gia_pkg::RATE_W-1:0]     avg_z;

    modport source (output valid, status, avg_x, avg_y, avg_z, input ready);
    modport sink   (input valid, status, avg_x, avg_y, avg_z, output ready);
endinterface

[rtl/gia_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_datapath
// Sample/query state, bit-serial interpolator and divider lanes, shared
// multiplier and the output register.
// ----------------------------------------------------------------------------
module gia_datapath #(
    parameter int unsigned MAX_INTERVAL_NS = 1073741824
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gia_in_if.sink            i_in,
    gia_out_if.source         o_out,
    input  gia_pkg::t_cmd     i_cmd,
    output gia_pkg::t_stat    o_stat
);

    localparam int unsigned RATE_W = gia_pkg::RATE_W;
    localparam int unsigned TIME_W = gia_pkg::TIME_W;
    localparam int unsigned MAG_W  = gia_pkg::MAG_W;
    localparam int unsigned DT_W   = $clog2(MAX_INTERVAL_NS + 1);
    localparam int unsigned LEN_W  = DT_W + 1;
    localparam int unsigned SUM_W  = RATE_W + 1;
    localparam int unsigned INT_W  = SUM_W + DT_W;
    localparam int unsigned CNT_W  = $clog2(INT_W);
    localparam int unsigned REM_W  = TIME_W + 1;
    localparam logic [TIME_W-1:0] MAX_T = TIME_W'(MAX_INTERVAL_NS);

    // latched input beat
    logic                     r_kind;
    logic [TIME_W-1:0]        r_t, r_s, r_e;
    logic signed [RATE_W-1:0] r_r [3];

    // tracked state
    logic                     r_hist_valid, r_qa, r_qs;
    logic [TIME_W-1:0]        r_prev_t, r_istart, r_iend, r_seg_t;
    logic signed [RATE_W-1:0] r_prev_r [3];
    logic signed [RATE_W-1:0] r_seg_r [3];
    logic signed [INT_W-1:0]  r_integ [3];

    // interpolator lanes
    logic [TIME_W-1:0]        r_den, r_x;
    logic                     r_byp0;
    logic [MAG_W-1:0]         r_imag [3];
    logic [REM_W-1:0]         r_irem [3];
    logic [MAG_W:0]           r_iq [3];
    logic                     r_ineg [3];

    // multiplier and divider
    logic [CNT_W-1:0]         r_cnt;
    logic [1:0]               r_ax;
    logic [DT_W-1:0]          r_dt;
    logic signed [INT_W-1:0]  r_prod;
    logic [LEN_W-1:0]         r_len2;
    logic [INT_W-1:0]         r_quo [3];
    logic [LEN_W-1:0]         r_drem [3];
    logic                     r_dneg [3];

    // output register
    logic                     r_out_valid;
    logic [gia_pkg::STATUS_W-1:0] r_out_status;
    logic signed [RATE_W-1:0] r_out_avg [3];

    logic                     w_fire;
    logic signed [RATE_W-1:0] w_in_r [3];
    logic signed [RATE_W-1:0] w_ires [3];
    logic [REM_W-1:0]         w_irem_n [3];
    logic [MAG_W:0]           w_iq_n [3];
    logic [LEN_W-1:0]         w_drem_n [3];
    logic                     w_dbit [3];
    logic signed [RATE_W-1:0] w_avg [3];
    logic signed [SUM_W-1:0]  w_sum;
    logic [TIME_W-1:0]        w_tgt;
    logic [TIME_W-1:0]        w_span;

    assign w_in_r[0] = i_in.rate_x;
    assign w_in_r[1] = i_in.rate_y;
    assign w_in_r[2] = i_in.rate_z;

    assign i_in.ready = i_cmd.accept_en;
    assign w_fire     = i_in.valid & i_cmd.accept_en;
    assign w_tgt      = i_cmd.interp_tgt_end ? r_iend : r_istart;
    assign w_span     = r_e - r_s;

    always_comb begin
        logic [REM_W-1:0] v_r1, v_r2;
        logic [MAG_W:0]   v_q;
        logic [LEN_W:0]   v_sh;
        logic [INT_W-1:0] v_mag;
        logic signed [RATE_W+1:0] v_res;
        for (int k = 0; k < 3; k++) begin
            // one bit of floor(mag * x / den)
            v_q  = {r_iq[k][MAG_W-1:0], 1'b0};
            v_r1 = {r_irem[k][REM_W-2:0], 1'b0};
            if (v_r1 >= REM_W'(r_den)) begin
                v_r1 = v_r1 - REM_W'(r_den);
                v_q  = v_q + 1'b1;
            end
            if (r_imag[k][MAG_W-1]) begin
                v_r2 = v_r1 + REM_W'(r_x);
                if (v_r2 >= REM_W'(r_den)) begin
                    v_r2 = v_r2 - REM_W'(r_den);
                    v_q  = v_q + 1'b1;
                end
            end else begin
                v_r2 = v_r1;
            end
            w_irem_n[k] = v_r2;
            w_iq_n[k]   = v_q;

            v_res = r_ineg[k]
                  ? (RATE_W+2)'(r_prev_r[k]) - $signed({1'b0, r_iq[k][MAG_W-1:0]})
                  : (RATE_W+2)'(r_prev_r[k]) + $signed({1'b0, r_iq[k][MAG_W-1:0]});
            w_ires[k] = (r_byp0 || (r_x > r_den)) ? r_prev_r[k] : RATE_W'(v_res);

            // one restoring divide step
            v_sh        = {r_drem[k], r_quo[k][INT_W-1]};
            w_dbit[k]   = v_sh >= {1'b0, r_len2};
            w_drem_n[k] = w_dbit[k] ? LEN_W'(v_sh - {1'b0, r_len2}) : LEN_W'(v_sh);

            v_mag    = r_dneg[k] ? (~r_quo[k] + 1'b1) : r_quo[k];
            w_avg[k] = (i_cmd.out_code == gia_pkg::ST_OK) ? $signed(v_mag[RATE_W-1:0])
                                                          : '0;
        end
        w_sum = SUM_W'(r_seg_r[r_ax])
              + SUM_W'(i_cmd.use_er ? w_ires[r_ax] : r_r[r_ax]);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_valid <= 1'b0;
            r_qa         <= 1'b0;
            r_qs         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.prev_update) r_hist_valid <= 1'b1;
            if (i_cmd.q_arm) begin
                r_qa <= 1'b1;
                r_qs <= (r_prev_t == r_s);
            end else if (i_cmd.q_clear) begin
                r_qa <= 1'b0;
                r_qs <= 1'b0;
            end else if (i_cmd.seg_start) begin
                r_qs <= 1'b1;
            end
            if (i_cmd.out_load)    r_out_valid <= 1'b1;
            else if (o_out.ready)  r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_kind <= i_in.kind;
            r_t    <= i_in.sample_time;
            r_s    <= i_in.start_time;
            r_e    <= i_in.end_time;
            for (int k = 0; k < 3; k++) r_r[k] <= w_in_r[k];
        end
        if (i_cmd.q_arm) begin
            r_istart <= r_s;
            r_iend   <= r_e;
            r_seg_t  <= r_s;
            for (int k = 0; k < 3; k++) begin
                r_integ[k] <= '0;
                r_seg_r[k] <= r_prev_r[k];
            end
        end
        if (i_cmd.interp_init) begin
            r_den  <= r_t - r_prev_t;
            r_x    <= w_tgt - r_prev_t;
            r_byp0 <= (r_t <= r_prev_t) || (w_tgt < r_prev_t);
            r_cnt  <= CNT_W'(MAG_W - 1);
            for (int k = 0; k < 3; k++) begin
                logic signed [RATE_W:0] v_d;
                v_d = (RATE_W+1)'(r_r[k]) - (RATE_W+1)'(r_prev_r[k]);
                r_ineg[k] <= v_d[RATE_W];
                r_imag[k] <= v_d[RATE_W] ? MAG_W'(-v_d) : MAG_W'(v_d);
                r_irem[k] <= '0;
                r_iq[k]   <= '0;
            end
        end
        if (i_cmd.interp_step) begin
            r_cnt <= r_cnt - 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_imag[k] <= {r_imag[k][MAG_W-2:0], 1'b0};
                r_irem[k] <= w_irem_n[k];
                r_iq[k]   <= w_iq_n[k];
            end
        end
        if (i_cmd.seg_start) begin
            r_seg_t <= r_istart;
            for (int k = 0; k < 3; k++) r_seg_r[k] <= w_ires[k];
        end
        if (i_cmd.dt_load) r_dt <= DT_W'((i_cmd.dt_end ? r_iend : r_t) - r_seg_t);
        if (i_cmd.ax_clr)  r_ax <= '0;
        if (i_cmd.mul)     r_prod <= $signed(w_sum) * $signed({1'b0, r_dt});
        if (i_cmd.acc) begin
            r_integ[r_ax] <= r_integ[r_ax] + r_prod;
            r_ax          <= (r_ax == 2'd2) ? 2'd0 : r_ax + 1'b1;
        end
        if (i_cmd.div_init) begin
            r_len2 <= {DT_W'(r_iend - r_istart), 1'b0};
            r_cnt  <= CNT_W'(INT_W - 1);
            for (int k = 0; k < 3; k++) begin
                r_dneg[k] <= r_integ[k][INT_W-1];
                r_quo[k]  <= r_integ[k][INT_W-1] ? INT_W'(-r_integ[k]) : INT_W'(r_integ[k]);
                r_drem[k] <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            for (int k = 0; k < 3; k++) begin
                r_drem[k] <= w_drem_n[k];
                r_quo[k]  <= {r_quo[k][INT_W-2:0], w_dbit[k]};
            end
        end
        if (i_cmd.seg_advance) begin
            r_seg_t <= r_t;
            for (int k = 0; k < 3; k++) r_seg_r[k] <= r_r[k];
        end
        if (i_cmd.prev_update) begin
            r_prev_t <= r_t;
            for (int k = 0; k < 3; k++) r_prev_r[k] <= r_r[k];
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_code;
            for (int k = 0; k < 3; k++) r_out_avg[k] <= w_avg[k];
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.avg_x  = r_out_avg[0];
    assign o_out.avg_y  = r_out_avg[1];
    assign o_out.avg_z  = r_out_avg[2];

    assign o_stat.in_fire   = w_fire;
    assign o_stat.is_query  = r_kind;
    assign o_stat.bad_iv    = (r_e <= r_s) || (w_span > MAX_T);
    assign o_stat.no_cov    = !r_hist_valid || (r_s < r_prev_t);
    assign o_stat.ooo       = r_hist_valid && (r_t < r_prev_t);
    assign o_stat.qa        = r_qa;
    assign o_stat.qs        = r_qs;
    assign o_stat.start_hit = r_t >= r_istart;
    assign o_stat.end_hit   = r_t >= r_iend;
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.ax_last   = (r_ax == 2'd2);
    assign o_stat.out_free  = !r_out_valid || o_out.ready;

endmodule

[rtl/gia_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gia_ctrl
// Sequencer: decodes each beat and steps the datapath through it.
// ----------------------------------------------------------------------------
module gia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gia_pkg::t_stat    i_stat,
    output gia_pkg::t_cmd     o_cmd
);

    gia_pkg::t_state  r_state, n_state;
    gia_pkg::t_status r_code, n_code;
    logic             r_end, n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gia_pkg::S_IDLE;
            r_code  <= gia_pkg::ST_OK;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_end   <= n_end;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_code         = r_code;
        n_end          = r_end;
        o_cmd          = '0;
        o_cmd.out_code = r_code;
        o_cmd.use_er   = r_end;
        o_cmd.dt_end   = r_end;
        unique case (r_state)
            gia_pkg::S_IDLE: begin
                o_cmd.accept_en = 1'b1;
                if (i_stat.in_fire) n_state = gia_pkg::S_DECODE;
            end
            gia_pkg::S_DECODE: begin
                if (i_stat.is_query) begin
                    o_cmd.q_clear = 1'b1;
                    if (i_stat.bad_iv) begin
                        n_code  = gia_pkg::ST_BAD_INTERVAL;
                        n_state = gia_pkg::S_EMIT;
                    end else if (i_stat.no_cov) begin
                        n_code  = gia_pkg::ST_NO_COVERAGE;
                        n_state = gia_pkg::S_EMIT;
                    end else begin
                        o_cmd.q_arm = 1'b1;
                        n_state     = gia_pkg::S_IDLE;
                    end
                end else if (i_stat.ooo) begin
                    // stale sample is dropped; an active query aborts
                    if (i_stat.qa) begin
                        o_cmd.q_clear = 1'b1;
                        n_code        = gia_pkg::ST_OUT_OF_ORDER;
                        n_state       = gia_pkg::S_EMIT;
                    end else begin
                        n_state = gia_pkg::S_IDLE;
                    end
                end else if (i_stat.qa && !i_stat.qs && i_stat.start_hit) begin
                    n_state = gia_pkg::S_START_INIT;
                end else begin
                    n_state = gia_pkg::S_CHECK;
                end
            end
            gia_pkg::S_START_INIT: begin
                o_cmd.interp_init = 1'b1;
                n_state           = gia_pkg::S_START_STEP;
            end
            gia_pkg::S_START_STEP: begin
                o_cmd.interp_step = 1'b1;
                if (i_stat.cnt_zero) n_state = gia_pkg::S_START_SET;
            end
            gia_pkg::S_START_SET: begin
                o_cmd.seg_start = 1'b1;
                n_state         = gia_pkg::S_CHECK;
            end
            gia_pkg::S_CHECK: begin
                if (i_stat.qa && i_stat.qs) begin
                    n_end   = i_stat.end_hit;
                    n_state = i_stat.end_hit ? gia_pkg::S_END_INIT : gia_pkg::S_DT_LOAD;
                end else begin
                    n_end   = 1'b0;
                    n_state = gia_pkg::S_UPDATE;
                end
            end
            gia_pkg::S_END_INIT: begin
                o_cmd.interp_init    = 1'b1;
                o_cmd.interp_tgt_end = 1'b1;
                n_state              = gia_pkg::S_END_STEP;
            end
            gia_pkg::S_END_STEP: begin
                o_cmd.interp_step = 1'b1;
                if (i_stat.cnt_zero) n_state = gia_pkg::S_DT_LOAD;
            end
            gia_pkg::S_DT_LOAD: begin
                o_cmd.dt_load = 1'b1;
                o_cmd.ax_clr  = 1'b1;
                n_state       = gia_pkg::S_MUL;
            end
            gia_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = gia_pkg::S_ACC;
            end
            gia_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_stat.ax_last) n_state = gia_pkg::S_MUL;
                else if (r_end)      n_state = gia_pkg::S_DIV_INIT;
                else                 n_state = gia_pkg::S_UPDATE;
            end
            gia_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = gia_pkg::S_DIV_STEP;
            end
            gia_pkg::S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.cnt_zero) n_state = gia_pkg::S_UPDATE;
            end
            gia_pkg::S_UPDATE: begin
                o_cmd.prev_update = 1'b1;
                o_cmd.seg_advance = !r_end;
                o_cmd.q_clear     = r_end;
                n_code            = gia_pkg::ST_OK;
                n_state           = r_end ? gia_pkg::S_EMIT : gia_pkg::S_IDLE;
            end
            gia_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_end          = 1'b0;
                    n_state        = gia_pkg::S_IDLE;
                end
            end
            default: n_state = gia_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/gyro_interval_average_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_interval_average_top
// Mean three-axis gyro rate over a queried interval, trapezoidal integration.
// ----------------------------------------------------------------------------
// Input channel i_in carries gyro samples (kind 0) and interval queries
// (kind 1); output channel o_out carries one result beat per finished,
// rejected or aborted query. Beats move on valid && ready.
// One input beat is handled at a time. The longest work on a beat is done
// by the 25-step serial interpolator (run once for the interval start and
// once for its end, all axes in parallel) and by the bit-serial divider of
// one step per integral bit, which runs for the sample that closes the
// interval.
// A finished result sits in an output register; the next input beat is
// taken while it waits. If the receiver stalls, a further result holds the
// sequencer until the register frees up.
// Synchronous reset clears sample history, the active query and the output.
// ----------------------------------------------------------------------------
module gyro_interval_average_top #(
    parameter int unsigned MAX_INTERVAL_NS = 1073741824
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gia_in_if.sink    i_in,
    gia_out_if.source o_out
);

    gia_pkg::t_cmd  w_cmd;
    gia_pkg::t_stat w_stat;

    gia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gia_datapath #(
        .MAX_INTERVAL_NS (MAX_INTERVAL_NS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

[tb/sv/gyro_interval_average_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_interval_average_top_tb
// Self-checking bench for the gyro interval averager: samples and interval
// queries are driven on the input channel and every result beat is compared
// with a behavioral predictor of the trapezoidal mean.
// ----------------------------------------------------------------------------
module gyro_interval_average_top_tb;

    localparam longint unsigned MAX_IV = 64'd1073741824;
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam int unsigned WDOG_LIMIT = 20000;

    typedef struct packed {
        gia_pkg::t_status status;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] az;
    } t_avg_res;

    logic i_clk;
    logic i_rst_n;
    gia_in_if  in_ch ();
    gia_out_if out_ch ();

    gyro_interval_average_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // predictor state
    bit              hist_valid;
    longint unsigned prev_t;
    longint          prev_r [3];
    bit              q_act, q_started;
    longint unsigned iv_start, iv_end, seg_t;
    longint          seg_r [3];
    longint          integ [3];

    t_avg_res        avg_q [$];
    int              n_err;
    int              watchdog;
    bit              rx_hold;
    bit              rx_nostall;
    bit              tx_nogap;

    function automatic longint lerp_rate(longint unsigned ta, longint ra,
                                         longint unsigned tb, longint rb,
                                         longint unsigned t);
        longint unsigned den, x, mag, q, r;
        longint d;
        den = tb - ta;
        x = t - ta;
        d = rb - ra;
        mag = (d < 0) ? -d : d;
        q = 0;
        r = 0;
        if (tb <= ta || t < ta || x > den) return ra;
        for (int i = 24; i >= 0; i--) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin r -= den; q++; end
            if ((mag >> i) & 1) begin
                r += x;
                if (r >= den) begin r -= den; q++; end
            end
        end
        return (d < 0) ? ra - longint'(q) : ra + longint'(q);
    endfunction

    function automatic void push_res(gia_pkg::t_status st, longint a0, longint a1,
                                     longint a2);
        t_avg_res e;
        e.status = st;
        e.ax = a0[23:0];
        e.ay = a1[23:0];
        e.az = a2[23:0];
        avg_q.insert(avg_q.size(), e);
    endfunction

    task automatic predict_avg(logic kind, longint unsigned ts, longint rx, longint ry,
                               longint rz, longint unsigned s, longint unsigned e);
        longint r [3];
        longint er, avg [3];
        longint unsigned dt;
        longint len2;
        r[0] = rx; r[1] = ry; r[2] = rz;
        if (kind == KIND_QUERY) begin
            q_act = 0;
            q_started = 0;
            if (e <= s || e - s > MAX_IV) begin
                push_res(gia_pkg::ST_BAD_INTERVAL, 0, 0, 0);
            end else if (!hist_valid || s < prev_t) begin
                push_res(gia_pkg::ST_NO_COVERAGE, 0, 0, 0);
            end else begin
                q_act = 1;
                iv_start = s;
                iv_end = e;
                for (int k = 0; k < 3; k++) integ[k] = 0;
                if (prev_t == s) begin
                    q_started = 1;
                    seg_t = s;
                    for (int k = 0; k < 3; k++) seg_r[k] = prev_r[k];
                end
            end
            return;
        end
        if (hist_valid && ts < prev_t) begin
            if (q_act) begin
                q_act = 0;
                q_started = 0;
                push_res(gia_pkg::ST_OUT_OF_ORDER, 0, 0, 0);
            end
            return;
        end
        if (q_act && !q_started && ts >= iv_start) begin
            q_started = 1;
            seg_t = iv_start;
            for (int k = 0; k < 3; k++)
                seg_r[k] = lerp_rate(prev_t, prev_r[k], ts, r[k], iv_start);
        end
        if (q_act && q_started) begin
            if (ts < iv_end) begin
                dt = ts - seg_t;
                for (int k = 0; k < 3; k++) begin
                    integ[k] += (seg_r[k] + r[k]) * longint'(dt);
                    seg_r[k] = r[k];
                end
                seg_t = ts;
            end else begin
                dt = iv_end - seg_t;
                len2 = longint'(iv_end - iv_start) * 2;
                for (int k = 0; k < 3; k++) begin
                    er = lerp_rate(prev_t, prev_r[k], ts, r[k], iv_end);
                    integ[k] += (seg_r[k] + er) * longint'(dt);
                    avg[k] = integ[k] / len2;
                end
                q_act = 0;
                q_started = 0;
                push_res(gia_pkg::ST_OK, avg[0], avg[1], avg[2]);
            end
        end
        hist_valid = 1;
        prev_t = ts;
        for (int k = 0; k < 3; k++) prev_r[k] = r[k];
    endtask

    // valid stays up after a beat until the next gap or drain drops it
    task automatic send_item(logic kind, longint unsigned ts, logic [23:0] rx,
                             logic [23:0] ry, logic [23:0] rz,
                             longint unsigned s, longint unsigned e);
        int gap;
        gap = tx_nogap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= kind;
        in_ch.sample_time <= ts[62:0];
        in_ch.rate_x      <= rx;
        in_ch.rate_y      <= ry;
        in_ch.rate_z      <= rz;
        in_ch.start_time  <= s[62:0];
        in_ch.end_time    <= e[62:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_avg(kind, {1'b0, ts[62:0]}, longint'(signed'(rx)), longint'(signed'(ry)),
                    longint'(signed'(rz)), {1'b0, s[62:0]}, {1'b0, e[62:0]});
        @(negedge i_clk);
    endtask

    task automatic send_sample(longint unsigned ts, logic [23:0] rx, logic [23:0] ry,
                               logic [23:0] rz);
        send_item(KIND_SAMPLE, ts, rx, ry, rz, {32'd0, $urandom}, {32'd0, $urandom});
    endtask

    task automatic send_query(longint unsigned s, longint unsigned e);
        send_item(KIND_QUERY, {$urandom, $urandom}, 24'($urandom), 24'($urandom),
                  24'($urandom), s, e);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (avg_q.size() != 0) @(negedge i_clk);
        // a sample that closes nothing may still be in flight
        repeat (150) @(negedge i_clk);
    endtask

    function automatic logic [23:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 200) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_avg_res got, exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = gia_pkg::t_status'(out_ch.status);
            got.ax = out_ch.avg_x;
            got.ay = out_ch.avg_y;
            got.az = out_ch.avg_z;
            if (avg_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result beat %h", got);
            end else begin
                exp_r = avg_q.pop_front();
                if (got !== exp_r) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp st=%0d %h %h %h got st=%0d %h %h %h",
                                 exp_r.status, exp_r.ax, exp_r.ay, exp_r.az,
                                 got.status, got.ax, got.ay, got.az);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold) out_ch.ready <= 1'b0;
        else if (rx_nostall) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 19) < 12);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog > WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    longint unsigned now_t;

    task automatic test_directed();
        // no history yet, bad intervals, one over max length, start before history
        send_query(100, 200);
        send_query(200, 200);
        send_query(300, 200);
        send_query(1000, 1000 + MAX_IV + 1);
        send_sample(1000, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_query(999, 2000);
        // start on the sample, full length, extreme rates
        send_query(1000, 1000 + MAX_IV);
        send_sample(1000 + MAX_IV, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
        // interpolated start, equal stamps, end on a sample
        send_query(1000 + MAX_IV + 10, 1000 + MAX_IV + 500);
        send_sample(1000 + MAX_IV + 100, 24'h123456, 24'hFEDCBA, 24'h000001);
        send_sample(1000 + MAX_IV + 100, 24'h7FFFFF, 24'h800000, 24'h400000);
        send_sample(1000 + MAX_IV + 500, 24'h000010, 24'hFFFFF0, 24'h800000);
        // out of order with and without active query, abandoned query
        send_query(1000 + MAX_IV + 500, 1000 + MAX_IV + 900);
        send_sample(5, 24'h1, 24'h2, 24'h3);
        send_sample(7, 24'h1, 24'h2, 24'h3);
        send_query(1000 + MAX_IV + 500, 1000 + MAX_IV + 600);
        send_query(1000 + MAX_IV + 500, 1000 + MAX_IV + 700);
        send_sample(63'h7FFF_FFFF_FFFF_FFF0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_query(63'h7FFF_FFFF_FFFF_FFF0, 63'h7FFF_FFFF_FFFF_FFFF);
        send_sample(63'h7FFF_FFFF_FFFF_FFFF, 24'h800000, 24'h800000, 24'h800000);
        wait_drained();
    endtask

    task automatic random_session(int n_items);
        int i;
        longint unsigned s, e;
        now_t = {30'd0, 2'($urandom_range(0, 3)), $urandom};
        i = 0;
        send_sample(now_t, rand_rate(), rand_rate(), rand_rate());
        while (i < n_items) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_query({$urandom, $urandom}, {$urandom, $urandom});
                    i++;
                end
                1: begin
                    send_sample(now_t - $urandom_range(1, 1000), rand_rate(), rand_rate(),
                                rand_rate());
                    i++;
                end
                default: begin
                    // well-formed query followed by a run of samples
                    s = now_t + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3000));
                    e = s + (($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_IV)
                                                         : $urandom_range(1, 5000));
                    send_query(s, e);
                    i++;
                    while (now_t < e && i < n_items) begin
                        now_t += ($urandom_range(0, 5) == 0) ? 0
                               : (($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_IV)
                                                              : $urandom_range(1, 2000));
                        send_sample(now_t, rand_rate(), rand_rate(), rand_rate());
                        i++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1;
                repeat (3000) @(negedge i_clk);
                rx_hold = 0;
            end
            begin
                tx_nogap = 1;
                random_session(60);
                tx_nogap = 0;
            end
        join
        wait_drained();
    endtask

    task automatic test_random();
        random_session(700);
        wait_drained();
        rx_nostall = 1;
        tx_nogap = 1;
        random_session(150);
        rx_nostall = 0;
        tx_nogap = 0;
        random_session(700);
        wait_drained();
    endtask

    initial begin
        n_err = 0;
        watchdog = 0;
        rx_hold = 0;
        rx_nostall = 0;
        tx_nogap = 0;
        hist_valid = 0;
        prev_t = 0;
        q_act = 0;
        q_started = 0;
        iv_start = 0;
        iv_end = 0;
        seg_t = 0;
        for (int k = 0; k < 3; k++) begin
            prev_r[k] = 0; seg_r[k] = 0; integ[k] = 0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_SAMPLE;
        in_ch.sample_time = '0;
        in_ch.rate_x = '0;
        in_ch.rate_y = '0;
        in_ch.rate_z = '0;
        in_ch.start_time = '0;
        in_ch.end_time = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random();
        if (n_err == 0 && avg_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
